// ===== hw/rtl/stpd_pkg.sv =====
// Shared types and constants for the scope trigger and peak detector.
// Used by stpd_csr, stpd_track and scope_trigger_peak_detect_core.
package stpd_pkg;

   localparam int CODE_W        = 12;
   localparam int POS_W         = 11;
   localparam int STEP_W        = 4;
   localparam int CSR_AW        = 2;
   localparam int CSR_DW        = 12;
   localparam int WINDOW_MARGIN = 10;

   localparam logic [CODE_W-1:0] THRESHOLD_RESET  = 12'd2048;
   localparam logic [CODE_W-1:0] HYSTERESIS_RESET = 12'd40;
   localparam logic [STEP_W-1:0] STEP_RESET       = 4'd1;

   typedef enum logic [CSR_AW-1:0] {
      CSR_THRESHOLD  = 2'd0,
      CSR_HYSTERESIS = 2'd1,
      CSR_STEP       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0] ch1;
      logic [CODE_W-1:0] ch2;
      logic              upper;
      logic              last;
   } sample_type;

   typedef struct packed {
      logic [CODE_W-1:0] threshold;
      logic [CODE_W-1:0] hysteresis;
   } trig_cfg_type;

   typedef struct packed {
      logic              hit;
      logic [POS_W-1:0]  position;
      logic [CODE_W-1:0] pkpk_ch2;
      logic [CODE_W-1:0] pkpk_ch1;
   } result_type;

endpackage

// ===== hw/rtl/stpd_csr.sv =====
// Configuration registers for the scope trigger and peak detector.
// Holds threshold and hysteresis, and the search window limit derived from the step.
// Depends on stpd_pkg.
module stpd_csr #(
   parameter int HALF_LEN   = 1024,
   parameter int WAVE_WIDTH = 158,
   parameter int LIM_W      = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  logic [stpd_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [stpd_pkg::CSR_DW-1:0]   csr_wdata,
   output stpd_pkg::trig_cfg_type        cfg,
   output logic [LIM_W-1:0]              limit
);

   function automatic logic [LIM_W-1:0] window_limit(input logic [stpd_pkg::STEP_W-1:0] step);
      logic [LIM_W-1:0] prod;
      prod = LIM_W'(WAVE_WIDTH) * LIM_W'(step);
      return LIM_W'(HALF_LEN) - prod - LIM_W'(stpd_pkg::WINDOW_MARGIN);
   endfunction

   stpd_pkg::trig_cfg_type cfg_ff;
   logic [LIM_W-1:0]       limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold  <= stpd_pkg::THRESHOLD_RESET;
         cfg_ff.hysteresis <= stpd_pkg::HYSTERESIS_RESET;
         limit_ff          <= window_limit(stpd_pkg::STEP_RESET);
      end else if (csr_we) begin
         unique case (csr_addr)
            stpd_pkg::CSR_THRESHOLD: begin
               cfg_ff.threshold <= csr_wdata[stpd_pkg::CODE_W-1:0];
            end
            stpd_pkg::CSR_HYSTERESIS: begin
               cfg_ff.hysteresis <= csr_wdata[stpd_pkg::CODE_W-1:0];
            end
            stpd_pkg::CSR_STEP: begin
               limit_ff <= window_limit(csr_wdata[stpd_pkg::STEP_W-1:0]);
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg   = cfg_ff;
   assign limit = limit_ff;

endmodule

// ===== hw/rtl/stpd_track.sv =====
// Block state of the detector: running minimum and maximum per channel, sample count
// and the falling-edge search. Produces the result for the word being processed.
// Depends on stpd_pkg.
module stpd_track #(
   parameter int HALF_LEN = 1024,
   parameter int LIM_W    = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  stpd_pkg::sample_type   sample,
   input  stpd_pkg::trig_cfg_type cfg,
   input  logic [LIM_W-1:0]       limit,
   output stpd_pkg::result_type   result
);

   localparam int CODE_W = stpd_pkg::CODE_W;
   localparam int POS_W  = stpd_pkg::POS_W;
   localparam int CNT_W  = $clog2(HALF_LEN + 1);
   localparam int SUM_W  = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

   logic [CODE_W-1:0] ch1_min_ff, ch1_max_ff, ch2_min_ff, ch2_max_ff, prev_ch1_ff;
   logic [CODE_W-1:0] ch1_min_in, ch1_max_in, ch2_min_in, ch2_max_in;
   logic [CNT_W-1:0]  count_ff;
   logic              edge_seen_ff;
   logic [POS_W-1:0]  edge_pos_ff;
   logic [SUM_W-1:0]  base;
   logic [POS_W-1:0]  edge_pos_in;
   logic              in_window;
   logic              falling;
   logic              edge_now;

   always_comb begin
      ch1_min_in = (sample.ch1 < ch1_min_ff) ? sample.ch1 : ch1_min_ff;
      ch1_max_in = (sample.ch1 > ch1_max_ff) ? sample.ch1 : ch1_max_ff;
      ch2_min_in = (sample.ch2 < ch2_min_ff) ? sample.ch2 : ch2_min_ff;
      ch2_max_in = (sample.ch2 > ch2_max_ff) ? sample.ch2 : ch2_max_ff;

      base        = sample.upper ? SUM_W'(HALF_LEN) : '0;
      edge_pos_in = POS_W'(base + SUM_W'(count_ff));
      in_window   = (count_ff != '0) &&
                    ($signed(LIM_W'(count_ff)) < $signed(limit));
      falling     = ({1'b0, prev_ch1_ff} > ({1'b0, cfg.threshold} + {1'b0, cfg.hysteresis})) &&
                    (sample.ch1 <= cfg.threshold);
      edge_now    = !edge_seen_ff && in_window && falling;

      result.pkpk_ch1 = ch1_max_in - ch1_min_in;
      result.pkpk_ch2 = ch2_max_in - ch2_min_in;
      result.hit      = edge_seen_ff || edge_now;
      if (edge_now) begin
         result.position = edge_pos_in;
      end else if (edge_seen_ff) begin
         result.position = edge_pos_ff;
      end else begin
         result.position = POS_W'(base);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (go && sample.last)) begin
         ch1_min_ff   <= '1;
         ch1_max_ff   <= '0;
         ch2_min_ff   <= '1;
         ch2_max_ff   <= '0;
         prev_ch1_ff  <= '0;
         count_ff     <= '0;
         edge_seen_ff <= 1'b0;
         edge_pos_ff  <= '0;
      end else if (go) begin
         ch1_min_ff  <= ch1_min_in;
         ch1_max_ff  <= ch1_max_in;
         ch2_min_ff  <= ch2_min_in;
         ch2_max_ff  <= ch2_max_in;
         prev_ch1_ff <= sample.ch1;
         if (count_ff != CNT_W'(HALF_LEN)) begin
            count_ff <= count_ff + 1'b1;
         end
         if (edge_now) begin
            edge_seen_ff <= 1'b1;
            edge_pos_ff  <= edge_pos_in;
         end
      end
   end

`ifndef SYNTHESIS
   a_edge_needs_history: assert property (@(posedge clock) disable iff (reset)
      edge_seen_ff |-> (count_ff > CNT_W'(1)))
      else $error("edge recorded before two samples of the block");
   a_count_cleared_after_last: assert property (@(posedge clock) disable iff (reset)
      (go && sample.last) |=> (count_ff == '0) && !edge_seen_ff)
      else $error("block state not cleared after final sample");
   a_min_max_order: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (ch1_min_ff <= ch1_max_ff) && (ch2_min_ff <= ch2_max_ff))
      else $error("minimum above maximum inside a block");
`endif

endmodule

// ===== hw/rtl/scope_trigger_peak_detect_core.sv =====
// Top level of the scope trigger and peak detector.
// Depends on stpd_pkg, stpd_csr and stpd_track.
//
// Usage: sample pairs enter on the req_ channel, one word per cycle; req_tdata carries
// channel one and channel two codes, req_tuser says the block is the upper buffer half
// and req_tlast marks the final pair of a block. On that final word one result word
// leaves on the rsp_ channel with both peak-to-peak codes, the trigger position and a
// hit flag; other words give no result.
// Timing: a word is registered at the input and processed from that register; the result
// of a final word is registered in the output register that drives rsp_tvalid and
// rsp_tdata, where it is held until rsp_tready takes it.
// Throughput: one word per cycle unless stalled; a single compare-and-update stage.
// Stalls: while a result waits on rsp_tready, non-final words still pass; a final word
// waits in the input register and req_tready drops until the result is taken.
// Reset: synchronous, clears block state and the channels and restores register defaults.
// The user writes configuration via csr_ only while no block is in flight; unchecked.
module scope_trigger_peak_detect_core #(
   parameter int HALF_LEN   = 1024,
   parameter int WAVE_WIDTH = 158
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [23:0]                 req_tdata,   // ch1_sample, ch2_sample
   input  logic                        req_tuser,   // upper_half
   input  logic                        req_tlast,   // last_sample
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [39:0]                 rsp_tdata,   // pkpk_ch1, pkpk_ch2, trigger_position,
                                                    // trigger_hit, zero pad
   input  logic                        csr_we,
   input  logic [stpd_pkg::CSR_AW-1:0] csr_addr,
   input  logic [stpd_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int LIM_W = $clog2(HALF_LEN + 16 * WAVE_WIDTH + 16) + 1;

   stpd_pkg::sample_type   s1_ff;
   logic                   s1_valid_ff;
   logic                   s1_go;
   stpd_pkg::trig_cfg_type cfg;
   logic [LIM_W-1:0]       limit;
   stpd_pkg::result_type   result;
   stpd_pkg::result_type   rsp_ff;
   logic                   rsp_valid_ff;

   stpd_csr #(
      .HALF_LEN   (HALF_LEN),
      .WAVE_WIDTH (WAVE_WIDTH),
      .LIM_W      (LIM_W)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .limit     (limit)
   );

   stpd_track #(
      .HALF_LEN (HALF_LEN),
      .LIM_W    (LIM_W)
   ) u_track (
      .clock  (clock),
      .reset  (reset),
      .go     (s1_go),
      .sample (s1_ff),
      .cfg    (cfg),
      .limit  (limit),
      .result (result)
   );

   assign s1_go      = s1_valid_ff && !(s1_ff.last && rsp_valid_ff && !rsp_tready);
   assign req_tready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_ff.ch1   <= req_tdata[11:0];
         s1_ff.ch2   <= req_tdata[23:12];
         s1_ff.upper <= req_tuser;
         s1_ff.last  <= req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_ff.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ff.last) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.hit, rsp_ff.position, rsp_ff.pkpk_ch2, rsp_ff.pkpk_ch1};

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s1_ff.last && rsp_valid_ff)
      else $error("input stalled without a waiting final word");
   a_result_from_final_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(s1_go && s1_ff.last))
      else $error("result raised without a final word");
   a_held_word_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_go) |=> s1_valid_ff && $stable(s1_ff))
      else $error("stalled input word lost");
`endif

endmodule
